>>> hdl/bmhr_pkg.sv
// Shared types and constants for the button minimum-hold release filter.
// Used by bmhr_state, bmhr_check and button_min_hold_release_filter_core.
`default_nettype none

package bmhr_pkg;

    // Field widths of the stream payloads (fixed by the interface)
    localparam int unsigned BTN_FIELD_W = 24;
    localparam int unsigned NOW_W       = 32;
    localparam int unsigned HOLD_W      = 16;
    localparam int unsigned MODE_W      = 2;

    // Packed payload widths, padded to whole bytes
    localparam int unsigned S_DATA_RAW_W = NOW_W + BTN_FIELD_W + 1 + 2 * BTN_FIELD_W;
    localparam int unsigned S_DATA_W     = ((S_DATA_RAW_W + 7) / 8) * 8;
    localparam int unsigned M_DATA_RAW_W = 2 * BTN_FIELD_W + 1;
    localparam int unsigned M_DATA_W     = ((M_DATA_RAW_W + 7) / 8) * 8;

    // Parameter defaults
    localparam int unsigned NUM_BUTTONS_DEF = 24;
    localparam int unsigned TICK_BITS_DEF   = 32;

    localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd40;

    typedef enum logic [MODE_W-1:0] {
        MODE_SEND  = 2'd0,
        MODE_DONE  = 2'd1,
        MODE_CHECK = 2'd2,
        MODE_CLEAR = 2'd3
    } mode_t;

    // Event strobe from the input stage to the state block
    typedef struct packed {
        logic  fire;
        mode_t mode;
        logic  ok;
    } evt_ctl_t;

endpackage

`default_nettype wire

>>> hdl/bmhr_state.sv
// Delivery tracking state: in-flight mask, delivered mask, per-button press stamps.
// Depends on bmhr_pkg.
`default_nettype none

module bmhr_state #(
    parameter int unsigned NUM_BUTTONS = bmhr_pkg::NUM_BUTTONS_DEF,
    parameter int unsigned TICK_BITS   = bmhr_pkg::TICK_BITS_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire bmhr_pkg::evt_ctl_t     evt,
    input  wire logic [TICK_BITS-1:0]   now,
    input  wire logic [NUM_BUTTONS-1:0] sent,
    output logic [TICK_BITS-1:0]        stamp [NUM_BUTTONS],
    output logic [NUM_BUTTONS-1:0]      stamp_valid
);

    logic [NUM_BUTTONS-1:0] inflight_reg,  inflight_next;
    logic                   inflight_v_reg, inflight_v_next;
    logic [NUM_BUTTONS-1:0] delivered_reg, delivered_next;
    logic                   delivered_v_reg, delivered_v_next;
    logic [NUM_BUTTONS-1:0] stamp_v_reg,   stamp_v_next;
    logic [TICK_BITS-1:0]   stamp_reg [NUM_BUTTONS];

    logic [NUM_BUTTONS-1:0] prev;
    logic [NUM_BUTTONS-1:0] pressed;
    logic [NUM_BUTTONS-1:0] released;
    logic                   note;

    always_comb begin
        prev     = delivered_v_reg ? delivered_reg : '0;
        pressed  = inflight_reg & ~prev;
        released = prev & ~inflight_reg;
        note     = evt.fire && (evt.mode == bmhr_pkg::MODE_DONE) && evt.ok && inflight_v_reg;

        inflight_next    = inflight_reg;
        inflight_v_next  = inflight_v_reg;
        delivered_next   = delivered_reg;
        delivered_v_next = delivered_v_reg;
        stamp_v_next     = stamp_v_reg;

        if (evt.fire) begin
            case (evt.mode)
                bmhr_pkg::MODE_SEND: begin
                    inflight_next   = sent;
                    inflight_v_next = 1'b1;
                end
                bmhr_pkg::MODE_DONE: begin
                    if (note) begin
                        stamp_v_next     = (stamp_v_reg | pressed) & ~released;
                        delivered_next   = inflight_reg;
                        delivered_v_next = 1'b1;
                    end
                    inflight_v_next = 1'b0;
                end
                bmhr_pkg::MODE_CLEAR: begin
                    inflight_next    = '0;
                    inflight_v_next  = 1'b0;
                    delivered_next   = '0;
                    delivered_v_next = 1'b0;
                    stamp_v_next     = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg    <= '0;
            inflight_v_reg  <= 1'b0;
            delivered_reg   <= '0;
            delivered_v_reg <= 1'b0;
            stamp_v_reg     <= '0;
        end else begin
            inflight_reg    <= inflight_next;
            inflight_v_reg  <= inflight_v_next;
            delivered_reg   <= delivered_next;
            delivered_v_reg <= delivered_v_next;
            stamp_v_reg     <= stamp_v_next;
        end
    end

    // stamp values are only looked at behind their valid bit
    always_ff @(posedge aclk) begin
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            if (note && pressed[b]) begin
                stamp_reg[b] <= now;
            end
        end
    end

    assign stamp       = stamp_reg;
    assign stamp_valid = stamp_v_reg;

endmodule

`default_nettype wire

>>> hdl/bmhr_check.sv
// Per-button age check: one subtract-compare unit per button.
// Depends on bmhr_pkg.
`default_nettype none

module bmhr_check #(
    parameter int unsigned NUM_BUTTONS = bmhr_pkg::NUM_BUTTONS_DEF,
    parameter int unsigned TICK_BITS   = bmhr_pkg::TICK_BITS_DEF
) (
    input  wire logic [TICK_BITS-1:0]        now,
    input  wire logic [bmhr_pkg::HOLD_W-1:0] min_hold,
    input  wire logic [NUM_BUTTONS-1:0]      cur,
    input  wire logic [NUM_BUTTONS-1:0]      nxt,
    input  wire logic [TICK_BITS-1:0]        stamp [NUM_BUTTONS],
    input  wire logic [NUM_BUTTONS-1:0]      stamp_valid,
    output logic [NUM_BUTTONS-1:0]           held
);

    localparam int unsigned CMP_W =
        (TICK_BITS > bmhr_pkg::HOLD_W) ? TICK_BITS : bmhr_pkg::HOLD_W;

    logic [NUM_BUTTONS-1:0] rel;
    logic [TICK_BITS-1:0]   age [NUM_BUTTONS];

    always_comb begin
        rel = cur & ~nxt;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            // age wraps modulo 2^TICK_BITS
            age[b]  = now - stamp[b];
            held[b] = rel[b] && stamp_valid[b] && (CMP_W'(age[b]) < CMP_W'(min_hold));
        end
    end

endmodule

`default_nettype wire

>>> hdl/button_min_hold_release_filter_core.sv
// Path: input transaction into the input register, then the result register, then result valid.
// Throughput: one transaction per cycle while m_tready keeps the result register free; one result per input, in order.
// The input register refills while a result waits in the output register.
// Reset: synchronous active-low aresetn clears both stage valids and all
// delivery/press tracking; min_hold_ticks returns to 40.
`default_nettype none

module button_min_hold_release_filter_core #(
    parameter int unsigned NUM_BUTTONS = bmhr_pkg::NUM_BUTTONS_DEF,
    parameter int unsigned TICK_BITS   = bmhr_pkg::TICK_BITS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // config: min_hold_ticks
    input  wire logic                            cfg_we,
    input  wire logic [bmhr_pkg::HOLD_W-1:0]     cfg_wdata,
    // input events
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // now[31:0], sent_buttons[55:32], delivery_ok[56], shown_mask[80:57],
    // queued_mask[104:81], zero pad[111:105]
    input  wire logic [bmhr_pkg::S_DATA_W-1:0]   s_tdata,
    // mode[1:0]
    input  wire logic [bmhr_pkg::MODE_W-1:0]     s_tuser,
    // results
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // held_mask[23:0], effective_buttons[47:24], may_advance[48], zero pad[55:49]
    output logic [bmhr_pkg::M_DATA_W-1:0]        m_tdata
);

    localparam int unsigned BW = bmhr_pkg::BTN_FIELD_W;
    localparam int unsigned NW = bmhr_pkg::NOW_W;

    logic [bmhr_pkg::HOLD_W-1:0]  min_hold_reg;

    // input stage
    logic                         in_v_reg;
    bmhr_pkg::mode_t              mode_reg;
    logic [bmhr_pkg::S_DATA_W-1:0] data_reg;

    // result stage
    logic                         out_v_reg;
    logic [BW-1:0]                held_o_reg;
    logic [BW-1:0]                eff_o_reg;
    logic                         adv_o_reg;

    logic                         out_free;
    logic                         advance;

    logic [TICK_BITS-1:0]         now_t;
    logic [NUM_BUTTONS-1:0]       sent_m;
    logic                         ok;
    logic [NUM_BUTTONS-1:0]       cur_m;
    logic [NUM_BUTTONS-1:0]       nxt_m;
    logic [NUM_BUTTONS-1:0]       held_m;
    logic [BW-1:0]                held_f;
    logic [BW-1:0]                nxt_f;
    logic                         is_check;

    bmhr_pkg::evt_ctl_t           evt;
    logic [TICK_BITS-1:0]         stamp [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0]       stamp_valid;

    assign out_free = !out_v_reg || m_tready;
    assign advance  = in_v_reg && out_free;
    assign s_tready = !in_v_reg || out_free;

    // unpack; bits at or above NUM_BUTTONS are dropped by the casts
    assign now_t  = TICK_BITS'(data_reg[NW-1:0]);
    assign sent_m = NUM_BUTTONS'(data_reg[NW+BW-1:NW]);
    assign ok     = data_reg[NW+BW];
    assign cur_m  = NUM_BUTTONS'(data_reg[NW+2*BW:NW+BW+1]);
    assign nxt_m  = NUM_BUTTONS'(data_reg[NW+3*BW:NW+2*BW+1]);

    assign evt.fire = advance;
    assign evt.mode = mode_reg;
    assign evt.ok   = ok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_hold_reg <= bmhr_pkg::HOLD_RESET;
        end else if (cfg_we) begin
            min_hold_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg <= 1'b0;
        end else if (s_tready) begin
            in_v_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            mode_reg <= bmhr_pkg::mode_t'(s_tuser);
            data_reg <= s_tdata;
        end
    end

    bmhr_state #(
        .NUM_BUTTONS(NUM_BUTTONS),
        .TICK_BITS  (TICK_BITS)
    ) u_state (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .evt        (evt),
        .now        (now_t),
        .sent       (sent_m),
        .stamp      (stamp),
        .stamp_valid(stamp_valid)
    );

    bmhr_check #(
        .NUM_BUTTONS(NUM_BUTTONS),
        .TICK_BITS  (TICK_BITS)
    ) u_check (
        .now        (now_t),
        .min_hold   (min_hold_reg),
        .cur        (cur_m),
        .nxt        (nxt_m),
        .stamp      (stamp),
        .stamp_valid(stamp_valid),
        .held       (held_m)
    );

    assign is_check = (mode_reg == bmhr_pkg::MODE_CHECK);
    assign held_f   = BW'(held_m);
    assign nxt_f    = BW'(nxt_m);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (out_free) begin
            out_v_reg <= in_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            held_o_reg <= is_check ? held_f : '0;
            eff_o_reg  <= is_check ? (nxt_f | held_f) : '0;
            adv_o_reg  <= is_check && (held_f == '0);
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = bmhr_pkg::M_DATA_W'({adv_o_reg, eff_o_reg, held_o_reg});

endmodule

`default_nettype wire
